// ===== hdl/sicxe_pkg.sv =====
`timescale 1ns / 1ps
package sicxe_pkg;

   // Commands carried by an input transfer
   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_EXEC    = 2'd3
   } cmd_type;

   // Condition codes
   localparam logic [1:0] CC_NONE = 2'd0;
   localparam logic [1:0] CC_LT   = 2'd1;
   localparam logic [1:0] CC_EQ   = 2'd2;
   localparam logic [1:0] CC_GT   = 2'd3;

   // Register numbers
   localparam logic [3:0] RN_A  = 4'd0;
   localparam logic [3:0] RN_X  = 4'd1;
   localparam logic [3:0] RN_L  = 4'd2;
   localparam logic [3:0] RN_B  = 4'd3;
   localparam logic [3:0] RN_S  = 4'd4;
   localparam logic [3:0] RN_T  = 4'd5;
   localparam logic [3:0] RN_F  = 4'd6;
   localparam logic [3:0] RN_FL = 4'd7;
   localparam logic [3:0] RN_PC = 4'd8;
   localparam logic [3:0] RN_SW = 4'd9;

   // Format 2 opcodes
   localparam logic [7:0] OP_CLEAR = 8'hB4;
   localparam logic [7:0] OP_COMPR = 8'hA0;
   localparam logic [7:0] OP_TIXR  = 8'hB8;

   // Format 3/4 opcodes (low two bits masked)
   localparam logic [7:0] OP_LDA  = 8'h00;
   localparam logic [7:0] OP_LDB  = 8'h68;
   localparam logic [7:0] OP_LDT  = 8'h74;
   localparam logic [7:0] OP_LDCH = 8'h50;
   localparam logic [7:0] OP_COMP = 8'h28;
   localparam logic [7:0] OP_STA  = 8'h0C;
   localparam logic [7:0] OP_STX  = 8'h10;
   localparam logic [7:0] OP_STL  = 8'h14;
   localparam logic [7:0] OP_STCH = 8'h54;
   localparam logic [7:0] OP_J    = 8'h3C;
   localparam logic [7:0] OP_JEQ  = 8'h30;
   localparam logic [7:0] OP_JLT  = 8'h38;
   localparam logic [7:0] OP_JSUB = 8'h48;
   localparam logic [7:0] OP_RSUB = 8'h4C;
   localparam logic [7:0] OP_TD   = 8'hE0;
   localparam logic [7:0] OP_RD   = 8'hD8;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DECODE,
      ST_EXEC,
      ST_IND,
      ST_LOAD,
      ST_STORE,
      ST_RESP
   } state_type;

endpackage

// ===== hdl/sicxe_instruction_step.sv =====
`timescale 1ns / 1ps
// Memory and restart commands step FETCH then RESP; an instruction adds DECODE, EXEC, IND,
// LOAD, STORE as needed, paced by the single byte port (one byte per cycle, registered read).
// Throughput: one command at a time; the next is accepted once the result has transferred.
// Reset clears registers, condition code and configuration; the main memory keeps its
// contents and is undefined until written.
module sicxe_instruction_step #(
   parameter int ADDR_BITS = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[1:0], mem_address[21:2], mem_data[29:22], zero fill
   input  logic [31:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // read_data[7:0], acc_a[31:8], index_x[55:32], link_l[79:56], base_b[103:80],
   // reg_s_out[127:104], reg_t_out[151:128], prog_counter[175:152], cond_out[177:176],
   // at_end[178], zero fill
   output logic [183:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [19:0]  csr_wdata
);
   import sicxe_pkg::*;

   localparam int MEM_DEPTH = 2 ** ADDR_BITS;

   logic [7:0] mem [MEM_DEPTH];
   logic [ADDR_BITS-1:0] mem_addr;
   logic mem_we;
   logic [7:0] mem_wdata;
   logic [7:0] mem_rdata_ff;

   state_type state_ff, state_in;
   logic [23:0] ra_ff, rx_ff, rl_ff, rb_ff, rs_ff, rt_ff, rf_ff, rfl_ff, pc_ff;
   logic [23:0] ra_in, rx_in, rl_in, rb_in, rs_in, rt_in, rf_in, rfl_in, pc_in;
   logic [1:0]  cc_ff, cc_in;
   logic [19:0] start_ff, len_ff;
   logic [1:0]  cmd_ff, cmd_in;
   logic [19:0] maddr_ff, maddr_in;
   logic [7:0]  mdata_ff, mdata_in;
   logic [7:0]  rdata_ff, rdata_in;
   // instruction bytes
   logic [7:0]  op_ff, op_in, b1_ff, b1_in, b2_ff, b2_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [23:0] ea_ff, ea_in;
   logic [23:0] word_ff, word_in;
   logic [23:0] npc_ff, npc_in;

   // decoded fields
   logic ext, fn, fi, fx, fb, fp, imm;
   logic [7:0] opm;
   logic [19:0] disp;
   logic [23:0] ea_calc, r1v, r2v, rx_inc, operand;

   function automatic logic [1:0] cmp3(input logic [23:0] a, input logic [23:0] b);
      if (a == b) return CC_EQ;
      return (a > b) ? CC_GT : CC_LT;
   endfunction

   function automatic logic [23:0] rget(input logic [3:0] r,
         input logic [23:0] a, x, l, b, s, t, f, fl, pc, input logic [1:0] cc);
      case (r)
         RN_A:  return a;
         RN_X:  return x;
         RN_L:  return l;
         RN_B:  return b;
         RN_S:  return s;
         RN_T:  return t;
         RN_F:  return f;
         RN_FL: return fl;
         RN_PC: return pc;
         RN_SW: return {22'd0, cc};
         default: return 24'd0;
      endcase
   endfunction

   assign ext  = b1_ff[4];
   assign fn   = op_ff[1];
   assign fi   = op_ff[0];
   assign fx   = b1_ff[7];
   assign fb   = b1_ff[6];
   assign fp   = b1_ff[5];
   assign imm  = !fn && fi;
   assign opm  = {op_ff[7:2], 2'b00};
   assign disp = ext ? {b1_ff[3:0], b2_ff, mem_rdata_ff} : {8'd0, b1_ff[3:0], b2_ff};
   assign r1v  = rget(b1_ff[7:4], ra_ff, rx_ff, rl_ff, rb_ff, rs_ff, rt_ff, rf_ff, rfl_ff,
                      pc_ff, cc_ff);
   assign r2v  = rget(b1_ff[3:0], ra_ff, rx_ff, rl_ff, rb_ff, rs_ff, rt_ff, rf_ff, rfl_ff,
                      pc_ff, cc_ff);
   assign rx_inc = rx_ff + 24'd1;
   assign operand = imm ? ea_ff : word_ff;

   // effective address from displacement and base registers
   always_comb begin
      logic [23:0] t;
      t = {4'd0, disp};
      if (!ext && fp && disp[11]) t = t - 24'h1000;
      if (fx) t = t + rx_ff;
      if (fb) t = t + rb_ff;
      if (fp) t = t + npc_ff;
      ea_calc = t;
   end

   // main memory, one byte port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_addr];
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ra_ff <= '0; rx_ff <= '0; rl_ff <= '0; rb_ff <= '0; rs_ff <= '0;
         rt_ff <= '0; rf_ff <= '0; rfl_ff <= '0; pc_ff <= '0; cc_ff <= CC_NONE;
         start_ff <= '0; len_ff <= '0;
      end else begin
         state_ff <= state_in;
         ra_ff <= ra_in; rx_ff <= rx_in; rl_ff <= rl_in; rb_ff <= rb_in; rs_ff <= rs_in;
         rt_ff <= rt_in; rf_ff <= rf_in; rfl_ff <= rfl_in; pc_ff <= pc_in; cc_ff <= cc_in;
         if (csr_we && !csr_index) start_ff <= csr_wdata;
         if (csr_we && csr_index)  len_ff <= csr_wdata;
      end
      cmd_ff <= cmd_in; maddr_ff <= maddr_in; mdata_ff <= mdata_in; rdata_ff <= rdata_in;
      op_ff <= op_in; b1_ff <= b1_in; b2_ff <= b2_in; cnt_ff <= cnt_in;
      ea_ff <= ea_in; word_ff <= word_in; npc_ff <= npc_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (req_tvalid) state_in = ST_FETCH;
         ST_FETCH: begin
            if (cmd_ff != CMD_EXEC) state_in = ST_RESP;
            else if (cnt_ff == 3'd2) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (op_ff == 8'h00 || op_ff[7:4] == 4'hC || op_ff[7:4] == 4'hF ||
                  op_ff[7:4] == 4'hA || op_ff[7:4] == 4'hB) state_in = ST_RESP;
            else if (ext && cnt_ff != 3'd4) state_in = ST_DECODE;
            else state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (fn && !fi) state_in = ST_IND;
            else state_in = ST_LOAD;
         end
         ST_IND:
            if (cnt_ff == 3'd3) state_in = ST_LOAD;
         ST_LOAD: begin
            if (opm == OP_STA || opm == OP_STX || opm == OP_STL || opm == OP_STCH)
               state_in = ST_STORE;
            else if (cnt_ff == 3'd3 || imm ||
                  !(opm == OP_LDA || opm == OP_LDB || opm == OP_LDT || opm == OP_COMP ||
                    (opm == OP_LDCH && cnt_ff == 3'd1)))
               state_in = ST_RESP;
            else if (opm == OP_LDCH && cnt_ff == 3'd1) state_in = ST_RESP;
         end
         ST_STORE:
            if (opm == OP_STCH || cnt_ff == 3'd2) state_in = ST_RESP;
         ST_RESP:
            if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory port
   always_comb begin
      ra_in = ra_ff; rx_in = rx_ff; rl_in = rl_ff; rb_in = rb_ff; rs_in = rs_ff;
      rt_in = rt_ff; rf_in = rf_ff; rfl_in = rfl_ff; pc_in = pc_ff; cc_in = cc_ff;
      cmd_in = cmd_ff; maddr_in = maddr_ff; mdata_in = mdata_ff; rdata_in = rdata_ff;
      op_in = op_ff; b1_in = b1_ff; b2_in = b2_ff; cnt_in = cnt_ff;
      ea_in = ea_ff; word_in = word_ff; npc_in = npc_ff;
      mem_we = 1'b0;
      mem_wdata = 8'd0;
      mem_addr = pc_ff[ADDR_BITS-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            cmd_in = req_tdata[1:0];
            maddr_in = req_tdata[21:2];
            mdata_in = req_tdata[29:22];
            cnt_in = 3'd0;
            rdata_in = 8'd0;
            mem_addr = pc_ff[ADDR_BITS-1:0];
         end
         ST_FETCH: begin
            if (cmd_ff == CMD_WRITE) begin
               mem_addr = ADDR_BITS'(maddr_ff);
               mem_we = 1'b1;
               mem_wdata = mdata_ff;
            end else if (cmd_ff == CMD_READ) begin
               mem_addr = ADDR_BITS'(maddr_ff);
            end else if (cmd_ff == CMD_RESTART) begin
               ra_in = '0; rx_in = '0; rb_in = '0; rs_in = '0; rt_in = '0; rf_in = '0;
               rfl_in = '0; cc_in = CC_NONE;
               pc_in = {4'd0, start_ff};
               rl_in = {4'd0, len_ff};
            end else begin
               // byte n arrives in the cycle after its address
               mem_addr = ADDR_BITS'(pc_ff + 24'(cnt_ff));
               if (cnt_ff == 3'd1) op_in = mem_rdata_ff;
               if (cnt_ff == 3'd2) b1_in = mem_rdata_ff;
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_DECODE: begin
            // keep the fourth byte addressed so that it is ready on entry to EXEC
            mem_addr = ADDR_BITS'(pc_ff + 24'd3);
            if (cnt_ff == 3'd3) b2_in = mem_rdata_ff;
            cnt_in = cnt_ff + 3'd1;
            if (op_ff == 8'h00 || op_ff[7:4] == 4'hC || op_ff[7:4] == 4'hF) begin
               pc_in = pc_ff + 24'd1;
            end else if (op_ff[7:4] == 4'hA || op_ff[7:4] == 4'hB) begin
               pc_in = pc_ff + 24'd2;
               if (op_ff == OP_CLEAR) begin
                  case (b1_ff[7:4])
                     RN_A:  ra_in = '0;
                     RN_X:  rx_in = '0;
                     RN_L:  rl_in = '0;
                     RN_B:  rb_in = '0;
                     RN_S:  rs_in = '0;
                     RN_T:  rt_in = '0;
                     RN_F:  rf_in = '0;
                     RN_FL: rfl_in = '0;
                     RN_PC: pc_in = 24'd2;
                     RN_SW: cc_in = CC_NONE;
                     default: ;
                  endcase
               end else if (op_ff == OP_COMPR) begin
                  cc_in = cmp3(r1v, r2v);
               end else if (op_ff == OP_TIXR) begin
                  rx_in = rx_inc;
                  cc_in = cmp3(rx_inc, (b1_ff[7:4] == RN_X) ? rx_inc : r1v);
               end
            end else begin
               npc_in = pc_ff + (ext ? 24'd4 : 24'd3);
            end
         end
         ST_EXEC: begin
            // displacement complete in b2 / memory data; form target
            if (ext) b2_in = b2_ff;
            ea_in = ea_calc;
            pc_in = npc_ff;
            mem_addr = ea_calc[ADDR_BITS-1:0];
            cnt_in = 3'd1;
         end
         ST_IND: begin
            mem_addr = ADDR_BITS'(ea_ff + 24'(cnt_ff));
            word_in = {word_ff[15:0], mem_rdata_ff};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               ea_in = {word_ff[15:0], mem_rdata_ff};
               mem_addr = ea_in[ADDR_BITS-1:0];
               cnt_in = 3'd1;
            end
         end
         ST_LOAD: begin
            mem_addr = ADDR_BITS'(ea_ff + 24'(cnt_ff));
            word_in = {word_ff[15:0], mem_rdata_ff};
            cnt_in = cnt_ff + 3'd1;
            if (state_in == ST_STORE) cnt_in = 3'd0;
            if (state_in == ST_RESP) begin
               case (opm)
                  OP_LDA:  ra_in = imm ? ea_ff : word_in;
                  OP_LDB:  rb_in = imm ? ea_ff : word_in;
                  OP_LDT:  rt_in = imm ? ea_ff : word_in;
                  OP_LDCH: ra_in = {ra_ff[23:8], imm ? ea_ff[7:0] : mem_rdata_ff};
                  OP_COMP: cc_in = cmp3(ra_ff, imm ? ea_ff : word_in);
                  OP_J:    pc_in = ea_ff;
                  OP_JEQ:  if (cc_ff == CC_EQ) pc_in = ea_ff;
                  OP_JLT:  if (cc_ff == CC_LT) pc_in = ea_ff;
                  OP_JSUB: begin
                     rl_in = npc_ff;
                     pc_in = ea_ff;
                  end
                  OP_RSUB: pc_in = rl_ff;
                  OP_TD:   cc_in = CC_LT;
                  OP_RD: begin
                     ra_in = '0;
                     cc_in = CC_EQ;
                  end
                  default: ;
               endcase
            end
         end
         ST_STORE: begin
            mem_addr = ADDR_BITS'(ea_ff + 24'(cnt_ff));
            mem_we = 1'b1;
            cnt_in = cnt_ff + 3'd1;
            if (opm == OP_STCH) mem_wdata = ra_ff[7:0];
            else begin
               case (cnt_ff[1:0])
                  2'd0: mem_wdata = (opm == OP_STA) ? ra_ff[23:16] :
                                    (opm == OP_STX) ? rx_ff[23:16] : rl_ff[23:16];
                  2'd1: mem_wdata = (opm == OP_STA) ? ra_ff[15:8] :
                                    (opm == OP_STX) ? rx_ff[15:8] : rl_ff[15:8];
                  default: mem_wdata = (opm == OP_STA) ? ra_ff[7:0] :
                                    (opm == OP_STX) ? rx_ff[7:0] : rl_ff[7:0];
               endcase
            end
         end
         ST_RESP: begin
            if (cmd_ff == CMD_READ && cnt_ff == 3'd0) begin
               rdata_in = mem_rdata_ff;
               cnt_in = 3'd1;
            end
         end
         default: ;
      endcase
   end

   logic [24:0] end_addr;
   logic [7:0]  rdata_out;
   assign end_addr = {5'd0, start_ff} + {5'd0, len_ff};
   // read data is valid from the memory register on the first response cycle
   assign rdata_out = (cmd_ff == CMD_READ && cnt_ff == 3'd0) ? mem_rdata_ff :
                      (cmd_ff == CMD_READ) ? rdata_ff : 8'd0;

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_RESP);
      rsp_tdata  = {5'd0, ({1'b0, pc_ff} >= end_addr), cc_ff, pc_ff, rt_ff, rs_ff, rb_ff,
                    rl_ff, rx_ff, ra_ff, rdata_out};
   end

endmodule

// ===== hdl/sicxe_checker.sv =====
`timescale 1ns / 1ps
module sicxe_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [31:0]  req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [183:0] rsp_tdata
);
   import sicxe_pkg::*;

   // one command in flight at a time
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("accept while result pending");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");

   // accept leads to busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");

   // non-read results carry zero read data
   a_rd0: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[1:0] != CMD_READ |=> ##1
      (!rsp_tvalid || rsp_tdata[7:0] == 8'd0)) else $error("stray read data");

endmodule

bind sicxe_instruction_step sicxe_checker u_checker (.*);

// ===== tb/sicxe_step_checker.sv =====
`timescale 1ns / 1ps
module sicxe_step_checker #(
   parameter logic CSR_START_IDX  = 1'b0,
   parameter logic CSR_LENGTH_IDX = 1'b1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [183:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [19:0]  csr_wdata,
   output int           fail_count,
   output int           outstanding,
   output logic [23:0]  cur_x,
   output logic [23:0]  cur_b,
   output logic [23:0]  cur_pc
);
   import sicxe_pkg::*;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [23:0] acc_a;
      logic [23:0] index_x;
      logic [23:0] link_l;
      logic [23:0] base_b;
      logic [23:0] reg_s;
      logic [23:0] reg_t;
      logic [23:0] prog_counter;
      logic [1:0]  cond;
      logic        at_end;
   } step_result_type;

   logic [7:0]   mem_img [logic [19:0]];
   logic [23:0]  regs [0:8];
   logic [1:0]   cc;
   logic [19:0]  start_q;
   logic [19:0]  length_q;
   step_result_type state_q [$];

   function automatic logic [7:0] rd8(logic [23:0] a);
      return mem_img.exists(a[19:0]) ? mem_img[a[19:0]] : 8'h00;
   endfunction

   function automatic logic [23:0] rd24(logic [23:0] a);
      return {rd8(a), rd8(a + 24'd1), rd8(a + 24'd2)};
   endfunction

   function automatic void wr24(logic [23:0] a, logic [23:0] v);
      mem_img[a[19:0]]           = v[23:16];
      mem_img[a[19:0] + 20'd1]   = v[15:8];
      mem_img[a[19:0] + 20'd2]   = v[7:0];
   endfunction

   function automatic logic [23:0] reg_value(logic [3:0] r);
      if (r <= RN_PC) return regs[r];
      if (r == RN_SW) return {22'd0, cc};
      return 24'd0;
   endfunction

   function automatic logic [1:0] order_of(logic [23:0] a, logic [23:0] b);
      if (a == b) return CC_EQ;
      return (a > b) ? CC_GT : CC_LT;
   endfunction

   // Register-to-register instructions
   function automatic void run_format2(logic [7:0] op, logic [23:0] pc);
      logic [7:0] b1;
      b1 = rd8(pc + 24'd1);
      case (op)
         OP_CLEAR: begin
            if (b1[7:4] <= RN_PC) regs[b1[7:4]] = 24'd0;
            else if (b1[7:4] == RN_SW) cc = CC_NONE;
         end
         OP_COMPR: cc = order_of(reg_value(b1[7:4]), reg_value(b1[3:0]));
         OP_TIXR: begin
            regs[RN_X] = regs[RN_X] + 24'd1;
            cc = order_of(regs[RN_X], reg_value(b1[7:4]));
         end
         default: ;
      endcase
      regs[RN_PC] = regs[RN_PC] + 24'd2;
   endfunction

   // Memory-operand instructions
   function automatic void run_format34(logic [7:0] op, logic [23:0] pc);
      logic [7:0]  b1;
      logic [23:0] ea;
      logic [23:0] npc;
      logic        ext;
      logic        imm;
      b1  = rd8(pc + 24'd1);
      ext = b1[4];
      imm = (op[1:0] == 2'b01);
      ea  = {12'd0, b1[3:0], rd8(pc + 24'd2)};
      if (ext) ea = {4'd0, b1[3:0], rd8(pc + 24'd2), rd8(pc + 24'd3)};
      npc = pc + (ext ? 24'd4 : 24'd3);
      regs[RN_PC] = npc;
      // short displacement is signed only when PC-relative
      if (!ext && b1[5] && ea >= 24'h800) ea = ea - 24'h1000;
      if (b1[7]) ea = ea + regs[RN_X];
      if (b1[6]) ea = ea + regs[RN_B];
      if (b1[5]) ea = ea + npc;
      if (op[1:0] == 2'b10) ea = rd24(ea);
      case (op & 8'hFC)
         OP_LDA:  regs[RN_A] = imm ? ea : rd24(ea);
         OP_LDB:  regs[RN_B] = imm ? ea : rd24(ea);
         OP_LDT:  regs[RN_T] = imm ? ea : rd24(ea);
         OP_LDCH: regs[RN_A] = {regs[RN_A][23:8], imm ? ea[7:0] : rd8(ea)};
         OP_COMP: cc = order_of(regs[RN_A], imm ? ea : rd24(ea));
         OP_STA:  wr24(ea, regs[RN_A]);
         OP_STX:  wr24(ea, regs[RN_X]);
         OP_STL:  wr24(ea, regs[RN_L]);
         OP_STCH: mem_img[ea[19:0]] = regs[RN_A][7:0];
         OP_J:    regs[RN_PC] = ea;
         OP_JEQ:  if (cc == CC_EQ) regs[RN_PC] = ea;
         OP_JLT:  if (cc == CC_LT) regs[RN_PC] = ea;
         OP_JSUB: begin
            regs[RN_L]  = npc;
            regs[RN_PC] = ea;
         end
         OP_RSUB: regs[RN_PC] = regs[RN_L];
         OP_TD:   cc = CC_LT;
         OP_RD: begin
            regs[RN_A] = 24'd0;
            cc = CC_EQ;
         end
         default: ;
      endcase
   endfunction

   function automatic void step_once();
      logic [23:0] pc;
      logic [7:0]  op;
      pc = regs[RN_PC];
      op = rd8(pc);
      if (op == 8'h00 || op[7:4] == 4'hC || op[7:4] == 4'hF) regs[RN_PC] = pc + 24'd1;
      else if (op[7:4] == 4'hA || op[7:4] == 4'hB) run_format2(op, pc);
      else run_format34(op, pc);
   endfunction

   function automatic void clear_regs();
      for (int k = 0; k <= 8; k++) regs[k] = 24'd0;
      cc = CC_NONE;
   endfunction

   // Apply one command and queue the state it leaves behind
   function automatic void apply_command(logic [31:0] d);
      step_result_type r;
      r = '0;
      case (cmd_type'(d[1:0]))
         CMD_WRITE:   mem_img[d[21:2]] = d[29:22];
         CMD_READ:    r.read_data = rd8({4'd0, d[21:2]});
         CMD_RESTART: begin
            clear_regs();
            regs[RN_PC] = {4'd0, start_q};
            regs[RN_L]  = {4'd0, length_q};
         end
         default:     step_once();
      endcase
      r.acc_a        = regs[RN_A];
      r.index_x      = regs[RN_X];
      r.link_l       = regs[RN_L];
      r.base_b       = regs[RN_B];
      r.reg_s        = regs[RN_S];
      r.reg_t        = regs[RN_T];
      r.prog_counter = regs[RN_PC];
      r.cond         = cc;
      r.at_end       = ({1'b0, regs[RN_PC]} >= 25'(start_q) + 25'(length_q));
      state_q.push_back(r);
   endfunction

   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t mismatch %s: expected %h, got %h", $realtime, name, want, got);
      end
   endfunction

   // Compare one result transfer with the oldest expectation
   function automatic void check_result(logic [183:0] d);
      step_result_type w;
      if (state_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) $display("%0t result with nothing expected", $realtime);
         return;
      end
      w = state_q.pop_front();
      check_field("read_data", {16'd0, w.read_data}, {16'd0, d[7:0]});
      check_field("acc_a", w.acc_a, d[31:8]);
      check_field("index_x", w.index_x, d[55:32]);
      check_field("link_l", w.link_l, d[79:56]);
      check_field("base_b", w.base_b, d[103:80]);
      check_field("reg_s_out", w.reg_s, d[127:104]);
      check_field("reg_t_out", w.reg_t, d[151:128]);
      check_field("prog_counter", w.prog_counter, d[175:152]);
      check_field("cond_out", {22'd0, w.cond}, {22'd0, d[177:176]});
      check_field("at_end", {23'd0, w.at_end}, {23'd0, d[178]});
   endfunction

   initial fail_count = 0;

   // Track configuration, commands and results on each edge
   always @(posedge clock) begin
      if (reset) begin
         clear_regs();
         start_q  = 20'd0;
         length_q = 20'd0;
         state_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_START_IDX) start_q = csr_wdata;
            else if (csr_index == CSR_LENGTH_IDX) length_q = csr_wdata;
         end
         if (req_tvalid && req_tready) apply_command(req_tdata);
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
      end
      outstanding = state_q.size();
      cur_x  = regs[RN_X];
      cur_b  = regs[RN_B];
      cur_pc = regs[RN_PC];
   end

endmodule

// ===== tb/tb_sicxe_instruction_step.sv =====
`timescale 1ns / 1ps
module tb_sicxe_instruction_step;
   import sicxe_pkg::*;

   localparam logic CSR_START  = 1'b0;
   localparam logic CSR_LENGTH = 1'b1;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // command[1:0], mem_address[21:2], mem_data[29:22], zero fill
   logic [31:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // read_data[7:0], acc_a[31:8], index_x[55:32], link_l[79:56], base_b[103:80],
   // reg_s_out[127:104], reg_t_out[151:128], prog_counter[175:152], cond_out[177:176],
   // at_end[178], zero fill
   logic [183:0] rsp_tdata;
   logic         csr_we;
   logic         csr_index;
   logic [19:0]  csr_wdata;

   int           fail_count;
   int           outstanding;
   logic [23:0]  cur_x, cur_b, cur_pc;
   int           idle_pct;
   int           stall_pct;
   int           items_sent;
   logic         written [logic [19:0]];
   logic [19:0]  written_list [$];

   logic [7:0] mem_ops [17] = '{OP_LDA, OP_LDB, OP_LDT, OP_LDCH, OP_COMP, OP_STA, OP_STX,
                                OP_STL, OP_STCH, OP_J, OP_JEQ, OP_JLT, OP_JSUB, OP_RSUB,
                                OP_TD, OP_RD, 8'h90};

   sicxe_instruction_step dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   sicxe_step_checker #(
      .CSR_START_IDX(CSR_START), .CSR_LENGTH_IDX(CSR_LENGTH)
   ) step_chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding),
      .cur_x(cur_x), .cur_b(cur_b), .cur_pc(cur_pc)
   );

   always #2 clock = ~clock;

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #2ms;
      $display("tb_sicxe_instruction_step failed");
      $finish;
   end

   // Present one command and hold it until the transfer
   task automatic put_item(cmd_type cmd, logic [19:0] addr, logic [7:0] data);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, data, addr, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
      items_sent++;
      if (cmd == CMD_WRITE && !written.exists(addr)) begin
         written[addr] = 1'b1;
         written_list.push_back(addr);
      end
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic program_csr(logic [19:0] start, logic [19:0] length);
      wait_drained();
      repeat (20) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = CSR_START;
      csr_wdata = start;
      @(negedge clock);
      csr_index = CSR_LENGTH;
      csr_wdata = length;
      @(negedge clock);
      csr_we = 1'b0;
      put_item(CMD_RESTART, 20'($urandom), 8'($urandom));
   endtask

   function automatic logic [19:0] pick_cfg();
      case ($urandom_range(3))
         0:       return 20'h00000;
         1:       return 20'hFFFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic bit ranges_meet(logic [19:0] a, int la, logic [19:0] b, int lb);
      logic [19:0] d1, d2;
      d1 = a - b;
      d2 = b - a;
      return (d1 < lb) || (d2 < la);
   endfunction

   task automatic put_word(logic [19:0] a, logic [23:0] v);
      put_item(CMD_WRITE, a, v[23:16]);
      put_item(CMD_WRITE, a + 20'd1, v[15:8]);
      put_item(CMD_WRITE, a + 20'd2, v[7:0]);
   endtask

   // Lay down one instruction and every byte it will read, then execute it.
   // kind: 0 skipped byte, 1 register form, 2 memory form, other random
   task automatic run_exec(int kind, logic [7:0] base, bit fixed);
      logic [23:0] pc, npc, ea, ptr;
      logic [19:0] disp;
      logic [7:0]  op, b1;
      logic [1:0]  ni;
      logic        ext, xf, bf, pf;
      int          len, oplen;
      wait_drained();
      pc = cur_pc;
      if (kind > 2) kind = ($urandom_range(99) < 15) ? 0 : ($urandom_range(99) < 25 ? 1 : 2);
      if (kind == 0) begin
         case ($urandom_range(2))
            0:       op = 8'h00;
            1:       op = {4'hC, 4'($urandom)};
            default: op = {4'hF, 4'($urandom)};
         endcase
         put_item(CMD_WRITE, pc[19:0], op);
      end else if (kind == 1) begin
         case ($urandom_range(3))
            0:       op = OP_CLEAR;
            1:       op = OP_COMPR;
            2:       op = OP_TIXR;
            default: op = {3'b101, 5'($urandom)};
         endcase
         if (fixed) op = base;
         put_item(CMD_WRITE, pc[19:0], op);
         put_item(CMD_WRITE, pc[19:0] + 20'd1, 8'($urandom));
      end else begin
         if (!fixed) base = mem_ops[$urandom_range(16)];
         ni   = 2'($urandom);
         ext  = ($urandom_range(3) == 0);
         xf   = 1'($urandom);
         bf   = 1'($urandom);
         pf   = 1'($urandom);
         disp = ext ? 20'($urandom) : {8'd0, 12'($urandom)};
         len  = ext ? 4 : 3;
         npc  = pc + 24'(len);
         ea   = {4'd0, disp};
         if (!ext && pf && ea >= 24'h800) ea = ea - 24'h1000;
         if (xf) ea = ea + cur_x;
         if (bf) ea = ea + cur_b;
         if (pf) ea = ea + npc;
         // the pointer must not be overwritten by the instruction itself
         if (ni == 2'b10 && ranges_meet(ea[19:0], 3, pc[19:0], len)) ni = 2'b11;
         ptr = ea;
         if (ni == 2'b10) ptr = 24'($urandom);
         case (base)
            OP_LDA, OP_LDB, OP_LDT, OP_COMP: oplen = 3;
            OP_LDCH:                         oplen = 1;
            default:                         oplen = 0;
         endcase
         if (ni == 2'b01) oplen = 0;
         for (int k = 0; k < oplen; k++)
            put_item(CMD_WRITE, ptr[19:0] + 20'(k), 8'($urandom));
         if (ni == 2'b10) put_word(ea[19:0], ptr);
         op = base | {6'd0, ni};
         b1 = {xf, bf, pf, ext, ext ? disp[19:16] : disp[11:8]};
         put_item(CMD_WRITE, pc[19:0], op);
         put_item(CMD_WRITE, pc[19:0] + 20'd1, b1);
         put_item(CMD_WRITE, pc[19:0] + 20'd2, ext ? disp[15:8] : disp[7:0]);
         if (ext) put_item(CMD_WRITE, pc[19:0] + 20'd3, disp[7:0]);
      end
      put_item(CMD_EXEC, 20'($urandom), 8'($urandom));
   endtask

   task automatic set_phase(int p);
      case (p % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 53; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 53; end
         default: begin idle_pct = 7; stall_pct = 7; end
      endcase
   endtask

   initial begin
      int phase, next_phase, next_cfg, sel;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_START;
      csr_wdata  = '0;
      items_sent = 0;
      set_phase(0);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: wrap at the top of memory, data extremes, special operations
      program_csr(20'hFFFFE, 20'hFFFFF);
      put_item(CMD_WRITE, 20'hFFFFF, 8'h00);
      put_item(CMD_WRITE, 20'h00000, 8'hFF);
      put_item(CMD_READ, 20'hFFFFF, 8'hFF);
      put_item(CMD_READ, 20'h00000, 8'h00);
      run_exec(0, 8'h00, 1'b0);
      run_exec(2, OP_LDA, 1'b1);
      run_exec(1, OP_TIXR, 1'b1);
      run_exec(2, OP_RD, 1'b1);
      program_csr(20'h00000, 20'h00000);

      // Random: mostly well-formed instructions, some noise
      phase      = 0;
      next_phase = items_sent + 300;
      next_cfg   = items_sent + 200;
      while (items_sent < 1250) begin
         if (items_sent >= next_phase) begin
            phase++;
            set_phase(phase);
            next_phase += 300;
         end
         if (items_sent >= next_cfg) begin
            program_csr(pick_cfg(), pick_cfg());
            next_cfg += 200;
         end
         sel = $urandom_range(99);
         if (sel < 72) run_exec(3, 8'h00, 1'b0);
         else if (sel < 82) put_item(CMD_WRITE, 20'($urandom), 8'($urandom));
         else if (sel < 92)
            put_item(CMD_READ, written_list[$urandom_range(written_list.size() - 1)],
                     8'($urandom));
         else put_item(CMD_RESTART, 20'($urandom), 8'($urandom));
      end

      // Drain and give the verdict
      wait_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_sicxe_instruction_step passed");
      end else begin
         $display("tb_sicxe_instruction_step failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/sicxe_pkg.sv
hdl/sicxe_instruction_step.sv
hdl/sicxe_checker.sv
tb/sicxe_step_checker.sv
tb/tb_sicxe_instruction_step.sv
